// ===== src/ofs_pkg.sv =====
// Shared types, codes and width helpers for the offset set statistics block.
// Used by ofs_ctrl, ofs_datapath and the offset_set_statistics top level.
package ofs_pkg;

  // Fixed field widths
  localparam int REG_W       = 15;   // configuration register width
  localparam int FRAC_W      = 17;   // near_fraction, Q0.16 with room for one
  localparam int MEAN_W      = 24;   // mean and rms, Q16.8
  localparam int CNT_OUT_W   = 16;   // sample_count port
  localparam int CFG_IDX_W   = 2;
  localparam int FRAC_SHIFT  = 16;
  localparam int MEAN_SHIFT  = 8;
  localparam int SQ_SUM_MAX_W = 48;  // square sum only matters modulo 2^48

  // Parameter defaults
  localparam int DEF_COUNT_BITS  = 16;
  localparam int DEF_SAMPLE_BITS = 16;

  // Register reset values
  localparam logic [REG_W-1:0] CENTRE_RESET = 15'd1000;
  localparam logic [REG_W-1:0] WINDOW_RESET = 15'd100;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd1;

  // Input commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_DRAIN,
    ST_DIV,
    ST_SAVE,
    ST_SQRT,
    ST_DONE
  } ctrl_state_t;

  // Which statistic the shared divider works on
  typedef enum logic [1:0] {
    PH_NEAR,
    PH_ABS,
    PH_SQ
  } phase_t;

  typedef struct packed {
    logic   sample_en;
    logic   div_load;
    phase_t div_sel;
    logic   div_step;
    logic   save_en;
    phase_t save_sel;
    logic   sqrt_load;
    logic   sqrt_step;
    logic   out_load;
    logic   clear;
  } ctrl_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic count_zero;
  } dp_status_t;

  // Offset width: holds |displacement| and the centre register
  function automatic int off_w(int sb);
    return (sb > REG_W) ? sb : REG_W;
  endfunction

  function automatic int sq_w(int sb, int cb);
    int w;
    w = 2 * off_w(sb) + cb;
    return (w > SQ_SUM_MAX_W) ? SQ_SUM_MAX_W : w;
  endfunction

  // Divider dividend width (square sum shifted by the fraction bits)
  function automatic int div_w(int sb, int cb);
    return sq_w(sb, cb) + FRAC_SHIFT;
  endfunction

endpackage

// ===== src/ofs_datapath.sv =====
// Datapath: config registers, sample pipeline, accumulators, shared divider,
// square root unit and output registers. Depends on ofs_pkg.
module ofs_datapath
  import ofs_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [REG_W-1:0]              cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] displacement,
  input  ctrl_cmd_t                     cmd,
  output dp_status_t                    status,
  output logic [FRAC_W-1:0]             near_fraction,
  output logic [MEAN_W-1:0]             mean_abs_offset,
  output logic [MEAN_W-1:0]             rms_offset,
  output logic [CNT_OUT_W-1:0]          sample_count,
  output logic                          overflow
);

  localparam int OFF_W    = off_w(SAMPLE_BITS);
  localparam int ABS_W    = OFF_W + COUNT_BITS;
  localparam int SQ_W     = sq_w(SAMPLE_BITS, COUNT_BITS);
  localparam int DIV_W    = div_w(SAMPLE_BITS, COUNT_BITS);
  localparam int SQ_STEPS = (DIV_W + 1) / 2;
  localparam int RAD_W    = 2 * SQ_STEPS;

  logic [REG_W-1:0]       centre_offset;
  logic [REG_W-1:0]       near_window;
  logic [COUNT_BITS-1:0]  total_count;
  logic [COUNT_BITS-1:0]  near_count;
  logic                   dropped_flag;
  logic [ABS_W-1:0]       abs_offset_sum;
  logic [SQ_W-1:0]        square_offset_sum;

  logic                   p1_valid;
  logic                   p2_valid;
  logic [OFF_W-1:0]       p1_off;
  logic [2*OFF_W-1:0]     p2_sq;

  logic [COUNT_BITS-1:0]  div_rem;
  logic [DIV_W-1:0]       div_quo;
  logic [FRAC_W-1:0]      near_q;
  logic [MEAN_W-1:0]      abs_q;

  logic [RAD_W-1:0]       rad;
  logic [SQ_STEPS:0]      sq_rem;
  logic [SQ_STEPS-1:0]    sq_root;

  // Sample stage
  logic [SAMPLE_BITS-1:0] disp_u;
  logic [SAMPLE_BITS-1:0] mag_s;
  logic [OFF_W-1:0]       mag;
  logic [OFF_W-1:0]       centre_x;
  logic [OFF_W-1:0]       off;
  logic                   near_hit;
  logic                   saturated;
  logic [2*OFF_W-1:0]     off_ext;

  assign disp_u    = unsigned'(displacement);
  assign mag_s     = disp_u[SAMPLE_BITS-1] ? (~disp_u + 1'b1) : disp_u;
  assign mag       = OFF_W'(mag_s);
  assign centre_x  = OFF_W'(centre_offset);
  assign off       = (mag >= centre_x) ? (mag - centre_x) : (centre_x - mag);
  assign near_hit  = off < OFF_W'(near_window);
  assign saturated = &total_count;
  assign off_ext   = (2*OFF_W)'(p1_off);

  // Divider step: restoring, one quotient bit per cycle
  logic [COUNT_BITS:0] div_rem_sh;
  logic [COUNT_BITS:0] div_diff;
  logic                div_ge;
  logic [DIV_W-1:0]    dividend;

  assign div_rem_sh = {div_rem, div_quo[DIV_W-1]};
  assign div_diff   = div_rem_sh - {1'b0, total_count};
  assign div_ge     = div_rem_sh >= {1'b0, total_count};

  always_comb begin
    case (cmd.div_sel)
      PH_NEAR: dividend = DIV_W'({near_count, {FRAC_SHIFT{1'b0}}});
      PH_ABS:  dividend = DIV_W'({abs_offset_sum, {MEAN_SHIFT{1'b0}}});
      PH_SQ:   dividend = DIV_W'({square_offset_sum, {FRAC_SHIFT{1'b0}}});
      default: dividend = '0;
    endcase
  end

  // Square root step: two radicand bits per cycle
  logic [SQ_STEPS+2:0] sq_rem_sh;
  logic [SQ_STEPS+2:0] sq_trial;
  logic [SQ_STEPS+2:0] sq_diff;
  logic                sq_ge;

  assign sq_rem_sh = {sq_rem, rad[RAD_W-1 -: 2]};
  assign sq_trial  = {1'b0, sq_root, 2'b01};
  assign sq_diff   = sq_rem_sh - sq_trial;
  assign sq_ge     = sq_rem_sh >= sq_trial;

  assign status.pipe_busy  = p1_valid | p2_valid;
  assign status.count_zero = (total_count == '0);

  // Control-carrying state
  always_ff @(posedge clk) begin
    if (rst) begin
      centre_offset     <= CENTRE_RESET;
      near_window       <= WINDOW_RESET;
      total_count       <= '0;
      near_count        <= '0;
      dropped_flag      <= 1'b0;
      abs_offset_sum    <= '0;
      square_offset_sum <= '0;
      p1_valid          <= 1'b0;
      p2_valid          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CENTRE: centre_offset <= cfg_data;
          CFG_WINDOW: near_window   <= cfg_data;
          default:    ;
        endcase
      end
      p1_valid <= 1'b0;
      if (cmd.sample_en) begin
        if (saturated) begin
          dropped_flag <= 1'b1;
        end else begin
          total_count <= total_count + 1'b1;
          if (near_hit) begin
            near_count <= near_count + 1'b1;
          end
          p1_valid <= 1'b1;
        end
      end
      p2_valid <= p1_valid;
      if (p1_valid) begin
        abs_offset_sum <= abs_offset_sum + ABS_W'(p1_off);
      end
      if (p2_valid) begin
        square_offset_sum <= square_offset_sum + SQ_W'(p2_sq);
      end
      if (cmd.clear) begin
        total_count       <= '0;
        near_count        <= '0;
        dropped_flag      <= 1'b0;
        abs_offset_sum    <= '0;
        square_offset_sum <= '0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.sample_en) begin
      p1_off <= off;
    end
    p2_sq <= off_ext * off_ext;

    if (cmd.div_load) begin
      div_rem <= '0;
      div_quo <= dividend;
    end else if (cmd.div_step) begin
      div_rem <= div_ge ? div_diff[COUNT_BITS-1:0] : div_rem_sh[COUNT_BITS-1:0];
      div_quo <= {div_quo[DIV_W-2:0], div_ge};
    end

    if (cmd.save_en) begin
      case (cmd.save_sel)
        PH_NEAR: near_q <= div_quo[FRAC_W-1:0];
        PH_ABS:  abs_q  <= div_quo[MEAN_W-1:0];
        default: ;
      endcase
    end

    if (cmd.sqrt_load) begin
      rad     <= RAD_W'(div_quo);
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (cmd.sqrt_step) begin
      rad     <= {rad[RAD_W-3:0], 2'b00};
      sq_rem  <= sq_ge ? sq_diff[SQ_STEPS:0] : sq_rem_sh[SQ_STEPS:0];
      sq_root <= {sq_root[SQ_STEPS-2:0], sq_ge};
    end

    if (cmd.out_load) begin
      near_fraction   <= status.count_zero ? '0 : near_q;
      mean_abs_offset <= status.count_zero ? '0 : abs_q;
      rms_offset      <= status.count_zero ? '0 : MEAN_W'(sq_root);
      sample_count    <= CNT_OUT_W'(total_count);
      overflow        <= dropped_flag;
    end
  end

endmodule

// ===== src/ofs_ctrl.sv =====
// Controller: sequences sample intake, the finish computation and the output
// register handshake. Depends on ofs_pkg.
module ofs_ctrl
  import ofs_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  localparam int DIV_W    = div_w(SAMPLE_BITS, COUNT_BITS);
  localparam int SQ_STEPS = (DIV_W + 1) / 2;
  localparam int STEP_W   = $clog2(DIV_W);

  ctrl_state_t       state, state_next;
  phase_t            phase, phase_next;
  logic [STEP_W-1:0] cnt, cnt_next;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCUM;
      phase     <= PH_NEAR;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_ACCUM: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_SAMPLE) begin
            cmd.sample_en = 1'b1;
          end else begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          if (status.count_zero) begin
            state_next = ST_DONE;
          end else begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = PH_NEAR;
            phase_next   = PH_NEAR;
            cnt_next     = '0;
            state_next   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == STEP_W'(DIV_W - 1)) begin
          state_next = ST_SAVE;
        end
      end
      ST_SAVE: begin
        cmd.save_en  = 1'b1;
        cmd.save_sel = phase;
        cnt_next     = '0;
        case (phase)
          PH_NEAR: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = PH_ABS;
            phase_next   = PH_ABS;
            state_next   = ST_DIV;
          end
          PH_ABS: begin
            cmd.div_load = 1'b1;
            cmd.div_sel  = PH_SQ;
            phase_next   = PH_SQ;
            state_next   = ST_DIV;
          end
          default: begin
            cmd.sqrt_load = 1'b1;
            state_next    = ST_SQRT;
          end
        endcase
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt + 1'b1;
        if (cnt == STEP_W'(SQ_STEPS - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          cmd.clear    = 1'b1;
          state_next   = ST_ACCUM;
        end
      end
      default: state_next = ST_ACCUM;
    endcase
    out_valid_next = cmd.out_load | (out_valid & ~out_ready);
  end

endmodule

// ===== src/offset_set_statistics.sv =====
// Top level of the offset set statistics block: ofs_ctrl plus ofs_datapath.
// Depends on ofs_pkg, ofs_ctrl and ofs_datapath.
//
// Collects signed displacement samples (cmd = sample) and, on a finish
// transfer (cmd = finish), returns one result: the share of samples whose
// |(|displacement| - centre_offset)| lies below near_window (Q0.16), the mean
// absolute offset and the RMS offset (both Q16.8, truncated), the sample
// count and an overflow flag; then the set is cleared. An empty set returns
// zeros. Once the count reaches 2^COUNT_BITS - 1 further samples are dropped
// and overflow is raised. Rate: sample transfers are taken one per clock
// while no finish is in progress, into a three-stage accumulate pipeline
// (offset, square, sum). During a finish, a one-bit-per-clock shared divider
// runs three divisions by the sample count on DIV_W-bit dividends, where
// DIV_W = min(2*max(SAMPLE_BITS,15)+COUNT_BITS, 48) + 16 (64 at the
// defaults), then a two-bits-per-clock square root unit runs over the mean
// square. An empty set skips both and goes straight to the result.
// Results sit in an output register, so sample transfers for the next set
// are taken while a result waits on out_ready; the next finish holds until
// that register is free. Configuration writes (cfg_we, cfg_index, cfg_data)
// take effect at once and belong to idle periods; unused indexes are ignored.
module offset_set_statistics
  import ofs_pkg::*;
#(
  parameter int COUNT_BITS  = DEF_COUNT_BITS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [REG_W-1:0]              cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          cmd,
  input  logic signed [SAMPLE_BITS-1:0] displacement,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [FRAC_W-1:0]             near_fraction,
  output logic [MEAN_W-1:0]             mean_abs_offset,
  output logic [MEAN_W-1:0]             rms_offset,
  output logic [CNT_OUT_W-1:0]          sample_count,
  output logic                          overflow
);

  ctrl_cmd_t  dp_cmd;
  dp_status_t dp_status;

  // Sequencer: sample intake, divide/sqrt schedule, output handshake
  ofs_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  // Accumulators, arithmetic units and result registers
  ofs_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .displacement    (displacement),
    .cmd             (dp_cmd),
    .status          (dp_status),
    .near_fraction   (near_fraction),
    .mean_abs_offset (mean_abs_offset),
    .rms_offset      (rms_offset),
    .sample_count    (sample_count),
    .overflow        (overflow)
  );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for offset_set_statistics: directed table, then
// randomized sample sets under several register settings.
// Depends on ofs_pkg and the offset_set_statistics RTL.
module tb;
  import ofs_pkg::*;

  localparam int CNT_BITS      = DEF_COUNT_BITS;
  localparam int SMP_BITS      = DEF_SAMPLE_BITS;
  localparam int IDLE_PCT      = 13;     // chance per cycle that a side idles
  localparam int HOLD_CYCLES   = 1500;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 12;     // accumulate pipeline plus margin
  localparam int DRAIN_CYCLES  = 300;    // longer than one full finish
  localparam int QUIET_LIMIT   = 20000;  // cycles with no transfer before giving up
  localparam int MAX_REPORTS   = 10;
  localparam int PHASE_ITEMS   = 150;
  localparam int MAG_MAX       = 1 << (SMP_BITS - 1);

  localparam logic [63:0] COUNT_LIMIT = (64'd1 << CNT_BITS) - 64'd1;

  // Indexes with no register behind them; writes there must do nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [FRAC_W-1:0]    near_fraction;
    logic [MEAN_W-1:0]    mean_abs_offset;
    logic [MEAN_W-1:0]    rms_offset;
    logic [CNT_OUT_W-1:0] sample_count;
    logic                 overflow;
  } stats_t;

  typedef struct packed {
    logic                       cmd;
    logic signed [SMP_BITS-1:0] disp;
    logic                       typed;   // use the hand-written result below
    stats_t                     want;
  } plan_row_t;

  localparam stats_t NO_STATS = '0;
  localparam int     PLAN_LEN = 19;

  // Directed rows run at the reset settings: centre 1000, window 100.
  // Single-sample sets have mean = rms = offset * 256, easy to read off.
  plan_row_t directed_plan [PLAN_LEN] = '{
    '{CMD_FINISH, 16'sd0,     1'b1, NO_STATS},  // empty set right after reset
    '{CMD_SAMPLE, 16'sd1000,  1'b0, NO_STATS},  // offset 0
    '{CMD_FINISH, 16'sd0,     1'b1, '{17'd65536, 24'd0, 24'd0, 16'd1, 1'b0}},
    '{CMD_SAMPLE, 16'sh8000,  1'b0, NO_STATS},  // most negative, offset 31768
    '{CMD_FINISH, -16'sd5,    1'b1, '{17'd0, 24'd8132608, 24'd8132608, 16'd1, 1'b0}},
    '{CMD_SAMPLE, 16'sd32767, 1'b0, NO_STATS},  // most positive, offset 31767
    '{CMD_FINISH, 16'sd77,    1'b1, '{17'd0, 24'd8132352, 24'd8132352, 16'd1, 1'b0}},
    '{CMD_SAMPLE, 16'sd0,     1'b0, NO_STATS},  // below centre, offset 1000
    '{CMD_FINISH, 16'sd0,     1'b1, '{17'd0, 24'd256000, 24'd256000, 16'd1, 1'b0}},
    '{CMD_SAMPLE, 16'sd1099,  1'b0, NO_STATS},  // window edges, both signs
    '{CMD_SAMPLE, -16'sd1100, 1'b0, NO_STATS},
    '{CMD_SAMPLE, 16'sd901,   1'b0, NO_STATS},
    '{CMD_SAMPLE, -16'sd900,  1'b0, NO_STATS},
    '{CMD_FINISH, 16'sd0,     1'b0, NO_STATS},
    '{CMD_FINISH, 16'sd0,     1'b1, NO_STATS},  // back-to-back finish: empty
    '{CMD_SAMPLE, -16'sd1,    1'b0, NO_STATS},
    '{CMD_SAMPLE, 16'sd21845, 1'b0, NO_STATS},
    '{CMD_SAMPLE, -16'sd21846,1'b0, NO_STATS},
    '{CMD_FINISH, 16'sh7fff,  1'b0, NO_STATS}
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = CFG_CENTRE;
  logic [REG_W-1:0]           cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       cmd = CMD_SAMPLE;
  logic signed [SMP_BITS-1:0] displacement = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [FRAC_W-1:0]          near_fraction;
  logic [MEAN_W-1:0]          mean_abs_offset;
  logic [MEAN_W-1:0]          rms_offset;
  logic [CNT_OUT_W-1:0]       sample_count;
  logic                       overflow;

  // Shadow of the block: registers and the running set.
  logic [REG_W-1:0] centre_reg;
  logic [REG_W-1:0] window_reg;
  logic [63:0]      set_abs_sum;
  logic [63:0]      set_sq_sum;
  logic [63:0]      set_near;
  logic [63:0]      set_count;
  logic             set_dropped;

  stats_t stats_due [$];   // results owed by the block, oldest first

  bit steady      = 1'b0;  // no idling on either side while set
  bit hold_req    = 1'b0;
  bit hold_served = 1'b0;
  int hold_left   = 0;
  int quiet_cycles = 0;
  bit timed_out   = 1'b0;
  int fail_count  = 0;

  offset_set_statistics #(
    .COUNT_BITS (CNT_BITS),
    .SAMPLE_BITS(SMP_BITS)
  ) uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .displacement   (displacement),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .near_fraction  (near_fraction),
    .mean_abs_offset(mean_abs_offset),
    .rms_offset     (rms_offset),
    .sample_count   (sample_count),
    .overflow       (overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bit-by-bit floor square root, widest root a 64-bit radicand can have.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic void clear_set();
    set_abs_sum = '0;
    set_sq_sum  = '0;
    set_near    = '0;
    set_count   = '0;
    set_dropped = 1'b0;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [REG_W-1:0] val);
    case (idx)
      CFG_CENTRE: centre_reg = val;
      CFG_WINDOW: window_reg = val;
      default: ;
    endcase
  endfunction

  // One input transfer through the shadow; a finish yields the statistics.
  task automatic step_offset_stats(input logic c, input logic signed [SMP_BITS-1:0] d,
                                   output bit got, output stats_t res);
    logic [63:0] mag;
    logic [63:0] off;
    got = 1'b0;
    res = '0;
    if (c == CMD_SAMPLE) begin
      // saturated count: the sample is dropped and only the flag changes
      if (set_count >= COUNT_LIMIT) begin
        set_dropped = 1'b1;
        return;
      end
      mag = {{(64 - SMP_BITS){1'b0}}, d};
      if (d[SMP_BITS-1]) mag = (64'd1 << SMP_BITS) - mag;
      off = (mag >= 64'(centre_reg)) ? mag - 64'(centre_reg) : 64'(centre_reg) - mag;
      set_abs_sum = set_abs_sum + off;
      set_sq_sum  = set_sq_sum + off * off;
      if (off < 64'(window_reg)) set_near = set_near + 64'd1;
      set_count = set_count + 64'd1;
    end else begin
      got = 1'b1;
      if (set_count != 0) begin
        res.near_fraction   = FRAC_W'((set_near << FRAC_SHIFT) / set_count);
        res.mean_abs_offset = MEAN_W'((set_abs_sum << MEAN_SHIFT) / set_count);
        res.rms_offset      = MEAN_W'(floor_sqrt((set_sq_sum << FRAC_SHIFT) / set_count));
      end
      res.sample_count = CNT_OUT_W'(set_count);
      res.overflow     = set_dropped;
      clear_set();
    end
  endtask

  // Offer one item; valid stays up until the transfer. Called at a clock edge
  // and returns at the edge of the transfer. in_ready is looked at on the
  // falling edge, where it is settled for the coming rising edge.
  task automatic push_item(input logic c, input logic signed [SMP_BITS-1:0] d,
                           output bit got, output stats_t res);
    int gap;
    bit took;
    gap = 0;
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    displacement <= d;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    step_offset_stats(c, d, got, res);
  endtask

  task automatic send(input logic c, input logic signed [SMP_BITS-1:0] d);
    bit     got;
    stats_t res;
    push_item(c, d, got, res);
    if (got) stats_due.insert(stats_due.size(), res);
  endtask

  // Quiet the input and let every owed result and the pipeline drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (stats_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers and junk to the spare indexes, one write per clock.
  task automatic load_config(input logic [REG_W-1:0] centre, input logic [REG_W-1:0] window);
    logic [CFG_IDX_W-1:0] idx_list [4];
    logic [REG_W-1:0]     val_list [4];
    idx_list = '{CFG_CENTRE, CFG_WINDOW, CFG_SPARE_LO, CFG_SPARE_HI};
    val_list = '{centre, window, REG_W'($urandom), REG_W'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx_list[i];
      cfg_data  <= val_list[i];
      @(posedge clk);
      apply_reg(idx_list[i], val_list[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Displacements aimed at the interesting spots of the current settings:
  // anywhere, around +/-centre, on the window edges, and the extremes.
  function automatic logic signed [SMP_BITS-1:0] pick_displacement();
    int mode;
    int mag;
    int span;
    logic signed [SMP_BITS-1:0] d;
    mode = $urandom_range(0, 9);
    if (mode < 4) return SMP_BITS'($urandom);
    span = int'(window_reg) + 3;
    if (mode < 7) begin
      mag = int'(centre_reg) + $urandom_range(0, 2 * span) - span;
    end else if (mode == 7) begin
      case ($urandom_range(0, 3))
        0: mag = int'(centre_reg) + int'(window_reg);
        1: mag = int'(centre_reg) - int'(window_reg);
        2: mag = int'(centre_reg) + int'(window_reg) - 1;
        default: mag = int'(centre_reg) - int'(window_reg) + 1;
      endcase
    end else begin
      case ($urandom_range(0, 4))
        0: mag = MAG_MAX;
        1: mag = MAG_MAX - 1;
        2: mag = 0;
        3: mag = 1;
        default: mag = int'(centre_reg);
      endcase
    end
    if (mag < 0) mag = 0;
    if (mag > MAG_MAX) mag = MAG_MAX;
    if (mag == MAG_MAX) begin
      d = {1'b1, {(SMP_BITS - 1){1'b0}}};
    end else begin
      d = SMP_BITS'(mag);
      if ($urandom_range(0, 1) == 1) d = -d;
    end
    return d;
  endfunction

  task automatic walk_directed_plan();
    bit     got;
    stats_t res;
    for (int i = 0; i < PLAN_LEN; i++) begin
      push_item(directed_plan[i].cmd, directed_plan[i].disp, got, res);
      if (got) begin
        stats_due.insert(stats_due.size(),
                         directed_plan[i].typed ? directed_plan[i].want : res);
      end
    end
  endtask

  // Random sets of mostly short length under one register setting. Every set
  // ends in a finish, so the phase leaves nothing in the pipeline.
  task automatic run_phase(input logic [REG_W-1:0] centre, input logic [REG_W-1:0] window,
                           input bit calm, input bit hold);
    int sent;
    int len;
    settle();
    load_config(centre, window);
    if (calm) steady <= 1'b1;
    if (hold) hold_req <= 1'b1;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 12);
      repeat (len) send(CMD_SAMPLE, pick_displacement());
      send(CMD_FINISH, SMP_BITS'($urandom));   // displacement ignored here
      sent += len + 1;
    end
    if (calm) steady <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off so the output register
  // stays full and the next finish backs up the input channel.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_req && !hold_served) begin
      hold_served = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  task automatic check_stats();
    stats_t seen;
    stats_t want;
    seen = '{near_fraction, mean_abs_offset, rms_offset, sample_count, overflow};
    if (stats_due.size() == 0) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: result with nothing owed: near %0d mean %0d rms %0d",
                 $time, seen.near_fraction, seen.mean_abs_offset, seen.rms_offset,
                 " count %0d ovf %0d", seen.sample_count, seen.overflow);
      return;
    end
    want = stats_due.pop_front();
    if (seen.near_fraction !== want.near_fraction ||
        seen.mean_abs_offset !== want.mean_abs_offset ||
        seen.rms_offset !== want.rms_offset ||
        seen.sample_count !== want.sample_count ||
        seen.overflow !== want.overflow) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: mismatch (exp/got) near %0d/%0d mean %0d/%0d rms %0d/%0d",
                 $time, want.near_fraction, seen.near_fraction,
                 want.mean_abs_offset, seen.mean_abs_offset, want.rms_offset, seen.rms_offset,
                 " count %0d/%0d ovf %0d/%0d",
                 want.sample_count, seen.sample_count, want.overflow, seen.overflow);
    end
  endtask

  // Falling-edge monitor: outputs are settled and mark what transfers at the
  // next rising edge. Also runs the no-transfer watchdog.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) check_stats();
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) timed_out = 1'b1;
    end
  end

  initial begin
    centre_reg = CENTRE_RESET;
    window_reg = WINDOW_RESET;
    clear_set();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    fork
      begin
        walk_directed_plan();
        run_phase('0, '0, 1'b0, 1'b0);                        // nothing is near
        run_phase('1, '1, 1'b0, 1'b0);                        // both at maximum
        run_phase(REG_W'($urandom), REG_W'($urandom_range(0, 400)), 1'b0, 1'b1);
        run_phase(REG_W'($urandom), REG_W'($urandom), 1'b1, 1'b0);
        run_phase('1, '0, 1'b0, 1'b0);
        run_phase(REG_W'($urandom_range(0, 3000)), REG_W'($urandom_range(0, 2000)),
                  1'b0, 1'b0);
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
      end
      wait (timed_out);
    join_any
    if (!timed_out && fail_count == 0 && stats_due.size() == 0) begin
      $display("** offset_set_statistics: PASSED **");
    end else begin
      $display("** offset_set_statistics: FAILED **");
    end
    $finish;
  end

endmodule

// ===== offset_set_statistics.f =====
src/ofs_pkg.sv
src/ofs_datapath.sv
src/ofs_ctrl.sv
src/offset_set_statistics.sv
dv/tb.sv
